/* rtl/core/i2cmq_pkg.sv */
package i2cmq_pkg;

  localparam int unsigned BYTE_W = 8;

  // request codes
  typedef enum logic [2:0] {
    REQ_BEGIN  = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_COUNT  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_POP    = 3'd4,
    REQ_EVENT  = 3'd5
  } req_e;

  // bus actions handed back with each result
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_SEND     = 3'd2,
    ACT_CONTINUE = 3'd3,
    ACT_ACK      = 3'd4,
    ACT_NACK     = 3'd5,
    ACT_RELEASE  = 3'd6,
    ACT_STOP     = 3'd7
  } action_e;

  // master status codes, prescaler bits masked
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  // queue controls from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // queue status towards the sequencer
  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } fifo_stat_t;

endpackage

/* rtl/core/i2c_master_queue_sequencer_core.sv */
// a request is captured in the request register, decoded, and its result loaded into the result register
// throughput: one request per cycle, results back to back while the output is not stalled
// the pace is set by the single decision stage between the request and result registers
// queue reads use registered ram ports aimed at the next oldest entries, with write bypass
// reset: queues empty, receive count and last status cleared, both channels empty
module i2c_master_queue_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       req_type_i,
  input  logic [6:0]       bus_address_i,
  input  logic             read_request_i,
  input  logic [7:0]       tx_byte_i,
  input  logic [7:0]       byte_count_i,
  input  logic [7:0]       bus_status_i,
  input  logic [7:0]       rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             accepted_o,
  output logic [2:0]       bus_action_o,
  output logic [7:0]       out_byte_o,
  output logic [7:0]       last_status_o,
  output logic [CNT_W-1:0] rx_count_o,
  output logic [7:0]       bytes_left_o,
  output logic             tx_empty_o
);

  // request register
  logic       in_valid_q;
  logic [2:0] req_type_q;
  logic [6:0] bus_address_q;
  logic       read_request_q;
  logic [7:0] tx_byte_q;
  logic [7:0] byte_count_q;
  logic [7:0] bus_status_q;
  logic [7:0] rx_byte_q;

  // result register
  logic                     out_valid_q;
  logic                     accepted_q, accepted_d;
  i2cmq_pkg::action_e       bus_action_q, bus_action_d;
  logic [7:0]               out_byte_q, out_byte_d;

  // sequencer state
  logic [7:0] pending_q, pending_d;
  logic [7:0] status_q, status_d;

  logic out_free;
  logic fire;

  i2cmq_pkg::fifo_ctrl_t tx_ctrl, rx_ctrl;
  i2cmq_pkg::fifo_stat_t tx_stat, rx_stat;
  logic [7:0]            tx_wdata;
  logic [7:0]            tx_head_data;
  logic [7:0]            tx_next_data;
  logic [7:0]            rx_head_data;
  logic [8:0]            pend_sum;
  logic [7:0]            pend_ev;
  logic [7:0]            pend_rx;

  // action once the transmit queue has nothing to send
  function automatic i2cmq_pkg::action_e idle_action(input logic [7:0] pend);
    if (pend == 8'd0) begin
      return i2cmq_pkg::ACT_RELEASE;
    end
    return (pend == 8'd1) ? i2cmq_pkg::ACT_NACK : i2cmq_pkg::ACT_CONTINUE;
  endfunction

  // handshake: the result register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pending_q   <= '0;
      status_q    <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= fire;
      end
      pending_q <= pending_d;
      status_q  <= status_d;
    end
  end

  // request payload capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_type_q     <= req_type_i;
      bus_address_q  <= bus_address_i;
      read_request_q <= read_request_i;
      tx_byte_q      <= tx_byte_i;
      byte_count_q   <= byte_count_i;
      bus_status_q   <= bus_status_i;
      rx_byte_q      <= rx_byte_i;
    end
  end

  // result payload capture
  always_ff @(posedge clk_i) begin
    if (fire) begin
      accepted_q   <= accepted_d;
      bus_action_q <= bus_action_d;
      out_byte_q   <= out_byte_d;
    end
  end

  assign pend_sum = {1'b0, pending_q} + {1'b0, byte_count_q};
  assign pend_ev  = (bus_status_q == i2cmq_pkg::ST_MR_SLA_NACK) ? 8'd0 : pending_q;
  assign pend_rx  = (pending_q != 8'd0) ? pending_q - 8'd1 : pending_q;

  // request decode and action choice
  always_comb begin
    accepted_d   = 1'b0;
    bus_action_d = i2cmq_pkg::ACT_NONE;
    out_byte_d   = '0;
    tx_ctrl      = '0;
    rx_ctrl      = '0;
    tx_wdata     = tx_byte_q;
    pending_d    = pending_q;
    status_d     = status_q;
    if (fire) begin
      case (i2cmq_pkg::req_e'(req_type_q))
        i2cmq_pkg::REQ_BEGIN: begin
          if (tx_stat.empty) begin
            tx_ctrl.push = 1'b1;
            tx_wdata     = {bus_address_q, read_request_q};
            accepted_d   = 1'b1;
            bus_action_d = i2cmq_pkg::ACT_START;
          end
        end
        i2cmq_pkg::REQ_WRITE: begin
          if (tx_stat.empty) begin
            tx_ctrl.push = 1'b1;
            accepted_d   = 1'b1;
            bus_action_d = i2cmq_pkg::ACT_SEND;
            out_byte_d   = tx_byte_q;
          end else if (!tx_stat.full) begin
            tx_ctrl.push = 1'b1;
            accepted_d   = 1'b1;
          end
        end
        i2cmq_pkg::REQ_COUNT: begin
          pending_d  = pend_sum[8] ? 8'hFF : pend_sum[7:0];
          accepted_d = 1'b1;
        end
        i2cmq_pkg::REQ_STOP: begin
          if (tx_stat.empty && (pending_q == 8'd0)) begin
            accepted_d   = 1'b1;
            bus_action_d = i2cmq_pkg::ACT_STOP;
          end
        end
        i2cmq_pkg::REQ_POP: begin
          if (!rx_stat.empty) begin
            rx_ctrl.pop = 1'b1;
            out_byte_d  = rx_head_data;
          end
          accepted_d = 1'b1;
        end
        i2cmq_pkg::REQ_EVENT: begin
          accepted_d = 1'b1;
          status_d   = bus_status_q;
          case (bus_status_q)
            i2cmq_pkg::ST_MT_SLA_ACK, i2cmq_pkg::ST_MT_SLA_NACK,
            i2cmq_pkg::ST_MT_DATA_ACK, i2cmq_pkg::ST_MT_DATA_NACK,
            i2cmq_pkg::ST_MR_SLA_ACK, i2cmq_pkg::ST_MR_SLA_NACK: begin
              // retire the byte just sent, then load the next one
              pending_d = pend_ev;
              if (!tx_stat.empty) begin
                tx_ctrl.pop = 1'b1;
              end
              if (!tx_stat.empty && !tx_stat.one_left) begin
                bus_action_d = i2cmq_pkg::ACT_SEND;
                out_byte_d   = tx_next_data;
              end else begin
                bus_action_d = idle_action(pend_ev);
              end
            end
            i2cmq_pkg::ST_START, i2cmq_pkg::ST_RESTART: begin
              if (!tx_stat.empty) begin
                bus_action_d = i2cmq_pkg::ACT_SEND;
                out_byte_d   = tx_head_data;
              end else begin
                bus_action_d = idle_action(pending_q);
              end
            end
            i2cmq_pkg::ST_MR_DATA_ACK, i2cmq_pkg::ST_MR_DATA_NACK: begin
              // store while bytes are owed, overwriting the oldest when full
              if (pending_q != 8'd0) begin
                rx_ctrl.push = 1'b1;
                rx_ctrl.pop  = rx_stat.full;
              end
              pending_d = pend_rx;
              if (pend_rx > 8'd1) begin
                bus_action_d = i2cmq_pkg::ACT_ACK;
              end else if (pend_rx == 8'd1) begin
                bus_action_d = i2cmq_pkg::ACT_NACK;
              end else begin
                bus_action_d = i2cmq_pkg::ACT_RELEASE;
              end
            end
            default: begin
              bus_action_d = i2cmq_pkg::ACT_CONTINUE;
            end
          endcase
        end
        default: begin
          accepted_d = 1'b0;
        end
      endcase
    end
  end

  i2cmq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_tx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tx_ctrl),
    .wdata_i     (tx_wdata),
    .stat_o      (tx_stat),
    .count_o     (),
    .head_data_o (tx_head_data),
    .next_data_o (tx_next_data)
  );

  i2cmq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_rx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rx_ctrl),
    .wdata_i     (rx_byte_q),
    .stat_o      (rx_stat),
    .count_o     (rx_count_o),
    .head_data_o (rx_head_data),
    .next_data_o ()
  );

  // outputs; state only moves when a result is loaded, so it matches the held result
  assign out_valid_o   = out_valid_q;
  assign accepted_o    = accepted_q;
  assign bus_action_o  = bus_action_q;
  assign out_byte_o    = out_byte_q;
  assign last_status_o = status_q;
  assign bytes_left_o  = pending_q;
  assign tx_empty_o    = tx_stat.empty;

`ifndef SYNTH
  tx_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_ctrl.push |-> !tx_stat.full)
    else $error("transmit queue written while full");

  rx_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_ctrl.pop |-> (!rx_stat.empty && (!rx_ctrl.push || rx_stat.full)))
    else $error("receive queue popped while empty");

  refused_has_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !accepted_q) |-> (bus_action_q == i2cmq_pkg::ACT_NONE))
    else $error("refused request carries a bus action");

  queue_moves_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> (tx_ctrl == '0 && rx_ctrl == '0 && pending_d == pending_q))
    else $error("state changed without a request");

  rx_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_count_o <= CNT_W'(QUEUE_DEPTH))
    else $error("receive fill level out of range");
`endif

endmodule

/* rtl/core/i2cmq_ram.sv */
module i2cmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // one write port, two registered read ports returning old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/core/i2cmq_fifo.sv */
module i2cmq_fifo #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2cmq_pkg::fifo_ctrl_t         ctrl_i,
  input  logic [i2cmq_pkg::BYTE_W-1:0]  wdata_i,
  output i2cmq_pkg::fifo_stat_t         stat_o,
  output logic [CNT_W-1:0]              count_o,
  output logic [i2cmq_pkg::BYTE_W-1:0]  head_data_o,
  output logic [i2cmq_pkg::BYTE_W-1:0]  next_data_o
);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic          last_push_q, last_push_d;
  logic [AW-1:0] raddr_b;
  logic          fwd_a_q, fwd_a_d;
  logic          fwd_b_q, fwd_b_d;
  logic [i2cmq_pkg::BYTE_W-1:0] fwd_data_q;
  logic [i2cmq_pkg::BYTE_W-1:0] rdata_a;
  logic [i2cmq_pkg::BYTE_W-1:0] rdata_b;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
    if (idx == AW'(DEPTH - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  // pointer update; a push with a pop keeps the last-operation flag
  always_comb begin
    head_d      = ctrl_i.push ? adv(head_q) : head_q;
    tail_d      = ctrl_i.pop ? adv(tail_q) : tail_q;
    last_push_d = last_push_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      last_push_d = 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      last_push_d = 1'b0;
    end
  end

  // the read ports follow the next oldest entry and the one after it
  assign raddr_b = adv(tail_d);
  assign fwd_a_d = ctrl_i.push && (head_q == tail_d);
  assign fwd_b_d = ctrl_i.push && (head_q == raddr_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      last_push_q <= 1'b0;
      fwd_a_q     <= 1'b0;
      fwd_b_q     <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      last_push_q <= last_push_d;
      fwd_a_q     <= fwd_a_d;
      fwd_b_q     <= fwd_b_d;
    end
  end

  // bypass for a write that lands on an address being read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      fwd_data_q <= wdata_i;
    end
  end

  i2cmq_ram #(
    .WIDTH (i2cmq_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ctrl_i.push),
    .waddr_i   (head_q),
    .wdata_i   (wdata_i),
    .raddr_a_i (tail_d),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign head_data_o = fwd_a_q ? fwd_data_q : rdata_a;
  assign next_data_o = fwd_b_q ? fwd_data_q : rdata_b;

  // status and fill level from the current pointers
  always_comb begin
    stat_o.empty    = (head_q == tail_q) && !last_push_q;
    stat_o.full     = (head_q == tail_q) && last_push_q;
    stat_o.one_left = !stat_o.empty && (adv(tail_q) == head_q);
    if (stat_o.full) begin
      count_o = CNT_W'(DEPTH);
    end else if (head_q >= tail_q) begin
      count_o = CNT_W'(head_q - tail_q);
    end else begin
      count_o = CNT_W'(head_q) + CNT_W'(DEPTH) - CNT_W'(tail_q);
    end
  end

endmodule

/* test/i2cmq_sequence_checker.sv */
module i2cmq_sequence_checker #(
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [2:0]       req_type_i,
  input  logic [6:0]       bus_address_i,
  input  logic             read_request_i,
  input  logic [7:0]       tx_byte_i,
  input  logic [7:0]       byte_count_i,
  input  logic [7:0]       bus_status_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             accepted_i,
  input  logic [2:0]       bus_action_i,
  input  logic [7:0]       out_byte_i,
  input  logic [7:0]       last_status_i,
  input  logic [CNT_W-1:0] rx_count_i,
  input  logic [7:0]       bytes_left_i,
  input  logic             tx_empty_i,
  output int               fail_count_o,
  output int               results_owed_o,
  output int               checked_o
);

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic               accepted;
    i2cmq_pkg::action_e action;
    logic [7:0]         data;
    logic [7:0]         status;
    logic [CNT_W-1:0]   fill;
    logic [7:0]         left;
    logic               tx_none;
  } seq_result_t;

  // shadow copy of the sequencer state
  logic [7:0] tx_mem [DEPTH];
  logic [3:0] tx_wr, tx_rd;
  logic       tx_was_push;
  logic [7:0] rx_mem [DEPTH];
  logic [3:0] rx_wr, rx_rd;
  logic       rx_was_push;
  logic [7:0] owed;
  logic [7:0] status_q;

  seq_result_t responses_due [$];
  int          errors;
  int          seen;

  function automatic logic tx_idle();
    return tx_wr == tx_rd && !tx_was_push;
  endfunction

  function automatic logic rx_full();
    return rx_wr == rx_rd && rx_was_push;
  endfunction

  function automatic void queue_tx(input logic [7:0] b);
    tx_mem[tx_rd + 4'(tx_wr - tx_rd)] = b;
    tx_wr++;
    tx_was_push = 1'b1;
  endfunction

  // next step once the transmit side has settled
  function automatic i2cmq_pkg::action_e after_tx(output logic [7:0] b);
    b = 8'h00;
    if (!tx_idle()) begin
      b = tx_mem[tx_rd];
      return i2cmq_pkg::ACT_SEND;
    end
    if (owed == 8'd1) return i2cmq_pkg::ACT_NACK;
    if (owed != 8'd0) return i2cmq_pkg::ACT_CONTINUE;
    return i2cmq_pkg::ACT_RELEASE;
  endfunction

  // expected response to one request, updating the shadow state
  function automatic seq_result_t sequencer_response(
    input logic [2:0] req,
    input logic [6:0] addr,
    input logic       rd,
    input logic [7:0] txb,
    input logic [7:0] cnt,
    input logic [7:0] st,
    input logic [7:0] rxb
  );
    seq_result_t r;
    logic [7:0]  b;
    logic        was_full;
    logic [3:0]  diff;
    int          sum;
    r = '0;
    r.action = i2cmq_pkg::ACT_NONE;
    b = 8'h00;
    case (req)
      i2cmq_pkg::REQ_BEGIN: begin
        if (tx_idle()) begin
          queue_tx({addr, rd});
          r.accepted = 1'b1;
          r.action = i2cmq_pkg::ACT_START;
        end
      end
      i2cmq_pkg::REQ_WRITE: begin
        if (tx_idle()) begin
          queue_tx(txb);
          r.accepted = 1'b1;
          r.action = i2cmq_pkg::ACT_SEND;
          r.data = txb;
        end else if (!(tx_wr == tx_rd && tx_was_push)) begin
          queue_tx(txb);
          r.accepted = 1'b1;
        end
      end
      i2cmq_pkg::REQ_COUNT: begin
        sum = int'(owed) + int'(cnt);
        owed = (sum > 255) ? 8'd255 : 8'(sum);
        r.accepted = 1'b1;
      end
      i2cmq_pkg::REQ_STOP: begin
        if (tx_idle() && owed == 8'd0) begin
          r.accepted = 1'b1;
          r.action = i2cmq_pkg::ACT_STOP;
        end
      end
      i2cmq_pkg::REQ_POP: begin
        if (!(rx_wr == rx_rd && !rx_was_push)) begin
          r.data = rx_mem[rx_rd];
          rx_rd++;
          rx_was_push = 1'b0;
        end
        r.accepted = 1'b1;
      end
      i2cmq_pkg::REQ_EVENT: begin
        r.accepted = 1'b1;
        status_q = st;
        case (st)
          i2cmq_pkg::ST_MR_SLA_NACK, i2cmq_pkg::ST_MT_SLA_ACK,
          i2cmq_pkg::ST_MT_SLA_NACK, i2cmq_pkg::ST_MT_DATA_ACK,
          i2cmq_pkg::ST_MT_DATA_NACK, i2cmq_pkg::ST_MR_SLA_ACK: begin
            // address nack in read mode drops whatever was still owed
            if (st == i2cmq_pkg::ST_MR_SLA_NACK) owed = 8'd0;
            if (!tx_idle()) begin
              tx_rd++;
              tx_was_push = 1'b0;
            end
            r.action = after_tx(b);
            r.data = b;
          end
          i2cmq_pkg::ST_START, i2cmq_pkg::ST_RESTART: begin
            r.action = after_tx(b);
            r.data = b;
          end
          i2cmq_pkg::ST_MR_DATA_ACK, i2cmq_pkg::ST_MR_DATA_NACK: begin
            // keep the newest bytes when the receive queue overflows
            if (owed != 8'd0) begin
              was_full = rx_full();
              rx_mem[rx_wr] = rxb;
              rx_wr++;
              if (was_full) rx_rd = rx_wr;
              rx_was_push = 1'b1;
              owed--;
            end
            if (owed > 8'd1) r.action = i2cmq_pkg::ACT_ACK;
            else if (owed == 8'd1) r.action = i2cmq_pkg::ACT_NACK;
            else r.action = i2cmq_pkg::ACT_RELEASE;
          end
          default: r.action = i2cmq_pkg::ACT_CONTINUE;
        endcase
      end
      default: ;
    endcase
    diff = rx_wr - rx_rd;
    r.status = status_q;
    r.fill = rx_full() ? CNT_W'(DEPTH) : CNT_W'(diff);
    r.left = owed;
    r.tx_none = tx_idle();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  // compare finished results, then predict newly accepted requests
  always @(posedge clk_i or negedge rst_ni) begin : watch
    seq_result_t want;
    if (!rst_ni) begin
      tx_wr = '0;
      tx_rd = '0;
      tx_was_push = 1'b0;
      rx_wr = '0;
      rx_rd = '0;
      rx_was_push = 1'b0;
      owed = '0;
      status_q = '0;
      responses_due.delete();
      results_owed_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (responses_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result arrived with no request outstanding");
        end else begin
          want = responses_due.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(accepted_i));
          check_field("bus_action", 8'(want.action), 8'(bus_action_i));
          check_field("out_byte", want.data, out_byte_i);
          check_field("last_status", want.status, last_status_i);
          check_field("rx_count", 8'(want.fill), 8'(rx_count_i));
          check_field("bytes_left", want.left, bytes_left_i);
          check_field("tx_empty", 8'(want.tx_none), 8'(tx_empty_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        responses_due.push_back(sequencer_response(req_type_i, bus_address_i, read_request_i,
                                                   tx_byte_i, byte_count_i, bus_status_i,
                                                   rx_byte_i));
      end
      results_owed_o <= responses_due.size();
    end
    fail_count_o <= errors;
    checked_o <= seen;
  end

endmodule

/* test/tb.sv */
module tb;

  // request codes the block does not know
  localparam logic [2:0] REQ_UNDEF_A = 3'd6;
  localparam logic [2:0] REQ_UNDEF_B = 3'd7;
  // status codes outside the sequencing table
  localparam logic [7:0] ST_NO_INFO   = 8'hF8;
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;

  localparam logic [7:0] KNOWN_ST [10] = '{
    i2cmq_pkg::ST_START, i2cmq_pkg::ST_RESTART, i2cmq_pkg::ST_MT_SLA_ACK,
    i2cmq_pkg::ST_MT_SLA_NACK, i2cmq_pkg::ST_MT_DATA_ACK, i2cmq_pkg::ST_MT_DATA_NACK,
    i2cmq_pkg::ST_MR_SLA_ACK, i2cmq_pkg::ST_MR_SLA_NACK, i2cmq_pkg::ST_MR_DATA_ACK,
    i2cmq_pkg::ST_MR_DATA_NACK
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [2:0] req_type = 3'd0;
  logic [6:0] bus_address = 7'd0;
  logic       read_request = 1'b0;
  logic [7:0] tx_byte = 8'd0;
  logic [7:0] byte_count = 8'd0;
  logic [7:0] bus_status = 8'd0;
  logic [7:0] rx_byte = 8'd0;
  logic       out_stall = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic       accepted;
  logic [2:0] bus_action;
  logic [7:0] out_byte;
  logic [7:0] last_status;
  logic [4:0] rx_count;
  logic [7:0] bytes_left;
  logic       tx_empty;

  int mismatches;
  int results_owed;
  int checked;
  int items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  i2c_master_queue_sequencer_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .bus_address_i  (bus_address),
    .read_request_i (read_request),
    .tx_byte_i      (tx_byte),
    .byte_count_i   (byte_count),
    .bus_status_i   (bus_status),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_o     (accepted),
    .bus_action_o   (bus_action),
    .out_byte_o     (out_byte),
    .last_status_o  (last_status),
    .rx_count_o     (rx_count),
    .bytes_left_o   (bytes_left),
    .tx_empty_o     (tx_empty)
  );

  i2cmq_sequence_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .bus_address_i  (bus_address),
    .read_request_i (read_request),
    .tx_byte_i      (tx_byte),
    .byte_count_i   (byte_count),
    .bus_status_i   (bus_status),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_i     (accepted),
    .bus_action_i   (bus_action),
    .out_byte_i     (out_byte),
    .last_status_i  (last_status),
    .rx_count_i     (rx_count),
    .bytes_left_i   (bytes_left),
    .tx_empty_i     (tx_empty),
    .fail_count_o   (mismatches),
    .results_owed_o (results_owed),
    .checked_o      (checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one request: a and b carry the fields that the request type uses
  task automatic issue(input logic [2:0] kind, input logic [7:0] a = 8'h00,
                       input logic [7:0] b = 8'h00);
    logic [6:0] addr;
    logic       rd;
    logic [7:0] txb, cnt, st, rxb;
    addr = 7'($urandom);
    rd = 1'($urandom);
    txb = 8'($urandom);
    cnt = 8'($urandom);
    st = 8'($urandom);
    rxb = 8'($urandom);
    case (kind)
      i2cmq_pkg::REQ_BEGIN: begin
        addr = a[6:0];
        rd = b[0];
      end
      i2cmq_pkg::REQ_WRITE: txb = a;
      i2cmq_pkg::REQ_COUNT: cnt = a;
      i2cmq_pkg::REQ_EVENT: begin
        st = a;
        rxb = b;
      end
      default: ;
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    bus_address <= addr;
    read_request <= rd;
    tx_byte <= txb;
    byte_count <= cnt;
    bus_status <= st;
    rx_byte <= rxb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items++;
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // corner cases in a fixed order
  task automatic directed_checks();
    issue(i2cmq_pkg::REQ_POP);
    issue(i2cmq_pkg::REQ_STOP);
    issue(i2cmq_pkg::REQ_BEGIN, 8'd127, 8'd1);
    issue(i2cmq_pkg::REQ_BEGIN, 8'd0, 8'd0);
    issue(i2cmq_pkg::REQ_WRITE, 8'h00);
    issue(i2cmq_pkg::REQ_STOP);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_START);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MT_SLA_ACK);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MT_DATA_ACK);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MT_DATA_ACK);
    issue(i2cmq_pkg::REQ_WRITE, 8'hFF);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MT_DATA_NACK);
    issue(i2cmq_pkg::REQ_COUNT, 8'd255);
    issue(i2cmq_pkg::REQ_COUNT, 8'd1);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_DATA_ACK, 8'hA5);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_SLA_NACK);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_DATA_NACK, 8'h3C);
    issue(i2cmq_pkg::REQ_EVENT, ST_NO_INFO);
    issue(i2cmq_pkg::REQ_EVENT, ST_BUS_ERROR);
    issue(i2cmq_pkg::REQ_POP);
    issue(REQ_UNDEF_A, 8'hFF, 8'hFF);
    issue(REQ_UNDEF_B, 8'hFF, 8'hFF);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_RESTART);
    issue(i2cmq_pkg::REQ_COUNT, 8'd2);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_SLA_ACK);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_DATA_ACK, 8'hFF);
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_DATA_NACK, 8'h00);
  endtask

  // write transfer, sometimes long enough to fill the transmit queue
  task automatic write_transfer();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 4);
    issue(i2cmq_pkg::REQ_BEGIN, 8'($urandom_range(127)), 8'd0);
    repeat (n) issue(i2cmq_pkg::REQ_WRITE, 8'($urandom));
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_START);
    issue(i2cmq_pkg::REQ_EVENT, ($urandom_range(9) == 0) ? i2cmq_pkg::ST_MT_SLA_NACK
                                                        : i2cmq_pkg::ST_MT_SLA_ACK);
    repeat (n) begin
      issue(i2cmq_pkg::REQ_EVENT, ($urandom_range(9) == 0) ? i2cmq_pkg::ST_MT_DATA_NACK
                                                          : i2cmq_pkg::ST_MT_DATA_ACK);
    end
    issue(i2cmq_pkg::REQ_STOP);
  endtask

  // read transfer, sometimes overrunning the receive queue or saturating the count
  task automatic read_transfer();
    int n, r, got;
    r = $urandom_range(99);
    if (r < 8) n = $urandom_range(200, 255);
    else if (r < 25) n = $urandom_range(17, 26);
    else n = $urandom_range(1, 6);
    issue(i2cmq_pkg::REQ_BEGIN, 8'($urandom_range(127)), 8'd1);
    issue(i2cmq_pkg::REQ_COUNT, 8'(n));
    issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_START);
    if ($urandom_range(9) == 0) begin
      issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_SLA_NACK);
    end else begin
      issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_SLA_ACK);
      got = (n > 30) ? $urandom_range(18, 30) : n;
      for (int i = 0; i < got; i++) begin
        issue(i2cmq_pkg::REQ_EVENT, (i == got - 1) ? i2cmq_pkg::ST_MR_DATA_NACK
                                                   : i2cmq_pkg::ST_MR_DATA_ACK,
              8'($urandom));
      end
      // abandon what is still owed
      if (got != n) issue(i2cmq_pkg::REQ_EVENT, i2cmq_pkg::ST_MR_SLA_NACK);
    end
    repeat ($urandom_range(0, 18)) issue(i2cmq_pkg::REQ_POP);
    issue(i2cmq_pkg::REQ_STOP);
  endtask

  // request with random type and content
  task automatic noise_request();
    logic [2:0] kind;
    logic [7:0] a;
    if ($urandom_range(39) == 0) kind = $urandom_range(1) ? REQ_UNDEF_A : REQ_UNDEF_B;
    else kind = 3'($urandom_range(5));
    a = $urandom_range(1) ? KNOWN_ST[$urandom_range(9)] : 8'($urandom);
    issue(kind, a, 8'($urandom));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    int stop_at, pick;
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    stop_at = items + count;
    while (items < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 4) write_transfer();
      else if (pick < 8) read_transfer();
      else repeat ($urandom_range(1, 4)) noise_request();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    wait_drained();
    run_phase(38, 48, 200);
    wait_drained();
    run_phase(48, 38, 200);
    wait_drained();
    run_phase(0, 0, 200);
    wait_drained();
    repeat (4) @(posedge clk);
    $display("%0d requests sent, %0d results compared", items, checked);
    $display("covered: corner cases, write and read transfers, random requests, three idle mixes");
    if (mismatches == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
